// File: rtl/thrc_pkg.sv
// Package for the thermostat relay controller with self-heating compensation.
// Holds field widths, reset values, division reciprocals, codes and shared structs.
// No dependencies; every other file of the block imports it.
package thrc_pkg;

    localparam int TIME_W     = 32;
    localparam int TEMP_W     = 12;
    localparam int OFS_W      = 16;
    localparam int RATE_W     = 16;
    localparam int MARGIN_W   = 10;
    localparam int FALL_W     = 10;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    // Whole seconds of a 32-bit millisecond count: (x * MS_RECIP) >> MS_SHIFT.
    localparam int MS_RECIP_W = 29;
    localparam int MS_SHIFT   = 38;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP = 29'd274877907;
    localparam int SECS_W     = 23;

    localparam int PROD_W = SECS_W + RATE_W;
    localparam int HEAT_W = OFS_W + 1;

    // Any heat amount of 65536 or more saturates the offsets the same way,
    // so the product is clamped before it is scaled by 1/10000.
    localparam logic [PROD_W-1:0] HEAT_SAT_LIMIT = 39'd655360000;
    localparam int SCALE_PRESHIFT = 4;
    localparam int SCALE_IN_W     = 26;
    localparam int SCALE_RECIP_W  = 27;
    localparam int SCALE_SHIFT    = 36;
    localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 27'd109951163;
    localparam logic [HEAT_W-1:0] HEAT_MAX = {1'b1, {OFS_W{1'b0}}};

    localparam logic signed [OFS_W-1:0] ON_GROWTH_LIMIT = 16'sd20;

    localparam logic signed [TEMP_W-1:0]   SETPOINT_RST       = 12'sd50;
    localparam logic signed [MARGIN_W-1:0] MARGIN_BELOW_RST   = 10'sd2;
    localparam logic signed [MARGIN_W-1:0] MARGIN_ABOVE_RST   = 10'sd0;
    localparam logic [FALL_W-1:0]          FALL_LIMIT_RST     = 10'd2;
    localparam logic [RATE_W-1:0]          HEAT_RATE_ON_RST   = 16'd100;
    localparam logic [RATE_W-1:0]          HEAT_RATE_OFF_RST  = 16'd100;
    localparam logic [TIME_W-1:0]          EVENT_INTERVAL_RST = 32'd60000;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } thrc_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT       = 3'd0,
        REG_MARGIN_BELOW   = 3'd1,
        REG_MARGIN_ABOVE   = 3'd2,
        REG_FALL_LIMIT     = 3'd3,
        REG_HEAT_RATE_ON   = 3'd4,
        REG_HEAT_RATE_OFF  = 3'd5,
        REG_EVENT_INTERVAL = 3'd6
    } thrc_reg_t;

    typedef struct packed {
        thrc_op_t                  op;
        logic [TIME_W-1:0]         now_ms;
        logic signed [TEMP_W-1:0]  raw_temp;
    } thrc_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_on;
        logic [TIME_W-1:0] time_off;
        logic [RATE_W-1:0] rate_on;
        logic [RATE_W-1:0] rate_off;
    } thrc_timing_t;

endpackage

// File: rtl/thrc_ctrl.sv
// Control state of the thermostat: configuration registers, relay, offsets and history.
// Applies one item per commit strobe using precomputed heat amounts.
// Depends on thrc_pkg.
module thrc_ctrl
    import thrc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     commit,
    input  thrc_item_t               item,
    input  logic [HEAT_W-1:0]        heat_on,
    input  logic [HEAT_W-1:0]        heat_off,
    output thrc_timing_t             timing,
    output logic                     relay_on,
    output logic signed [TEMP_W-1:0] temp_corrected
);

    logic signed [TEMP_W-1:0]   setpoint_reg;
    logic signed [MARGIN_W-1:0] margin_below_reg;
    logic signed [MARGIN_W-1:0] margin_above_reg;
    logic [FALL_W-1:0]          fall_limit_reg;
    logic [RATE_W-1:0]          heat_rate_on_reg;
    logic [RATE_W-1:0]          heat_rate_off_reg;
    logic [TIME_W-1:0]          event_interval_reg;

    logic                       relay_reg, relay_next;
    logic [TIME_W-1:0]          time_on_reg, time_on_next;
    logic [TIME_W-1:0]          time_off_reg, time_off_next;
    logic [TIME_W-1:0]          last_event_reg, last_event_next;
    logic signed [OFS_W-1:0]    offset_on_reg, offset_on_next;
    logic signed [OFS_W-1:0]    offset_off_reg, offset_off_next;
    logic signed [OFS_W-1:0]    offset_base_reg, offset_base_next;
    logic signed [TEMP_W-1:0]   ct_reg, ct_next;
    logic signed [TEMP_W-1:0]   hist1_reg, hist1_next;
    logic signed [TEMP_W-1:0]   hist2_reg, hist2_next;

    logic signed [OFS_W+1:0]    ofs_sum_on, ofs_sum_off;
    logic signed [OFS_W-1:0]    ofs_on_new, ofs_off_new;
    logic signed [OFS_W+1:0]    temp_on, temp_off;
    logic signed [TEMP_W:0]     thr_on, thr_off, d1, d2, fall13;
    logic [TIME_W-1:0]          elapsed;
    logic                       event_fire;
    logic                       relay_mid;
    logic signed [OFS_W-1:0]    on_mid;

    function automatic logic signed [OFS_W-1:0] sat_ofs(input logic signed [OFS_W+1:0] v);
        logic signed [OFS_W-1:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[OFS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [OFS_W+1:0] v);
        logic signed [TEMP_W-1:0] r;
        if (v > 18'sd2047)
            r = 12'sh7FF;
        else if (v < -18'sd2048)
            r = 12'sh800;
        else
            r = v[TEMP_W-1:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg       <= SETPOINT_RST;
            margin_below_reg   <= MARGIN_BELOW_RST;
            margin_above_reg   <= MARGIN_ABOVE_RST;
            fall_limit_reg     <= FALL_LIMIT_RST;
            heat_rate_on_reg   <= HEAT_RATE_ON_RST;
            heat_rate_off_reg  <= HEAT_RATE_OFF_RST;
            event_interval_reg <= EVENT_INTERVAL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SETPOINT:       setpoint_reg       <= cfg_wdata[TEMP_W-1:0];
                REG_MARGIN_BELOW:   margin_below_reg   <= cfg_wdata[MARGIN_W-1:0];
                REG_MARGIN_ABOVE:   margin_above_reg   <= cfg_wdata[MARGIN_W-1:0];
                REG_FALL_LIMIT:     fall_limit_reg     <= cfg_wdata[FALL_W-1:0];
                REG_HEAT_RATE_ON:   heat_rate_on_reg   <= cfg_wdata[RATE_W-1:0];
                REG_HEAT_RATE_OFF:  heat_rate_off_reg  <= cfg_wdata[RATE_W-1:0];
                REG_EVENT_INTERVAL: event_interval_reg <= cfg_wdata[TIME_W-1:0];
                default:            ;
            endcase
        end
    end

    assign ofs_sum_on  = (OFS_W+2)'(offset_off_reg) + (OFS_W+2)'({1'b0, heat_on});
    assign ofs_sum_off = (OFS_W+2)'(offset_base_reg) - (OFS_W+2)'({1'b0, heat_off});
    assign ofs_on_new  = (offset_on_reg <= ON_GROWTH_LIMIT) ? sat_ofs(ofs_sum_on) : offset_on_reg;
    assign ofs_off_new = sat_ofs(ofs_sum_off);
    assign temp_on     = (OFS_W+2)'($signed(item.raw_temp)) - (OFS_W+2)'(ofs_on_new);
    assign temp_off    = (OFS_W+2)'($signed(item.raw_temp)) - (OFS_W+2)'(ofs_off_new);

    assign thr_on  = (TEMP_W+1)'(setpoint_reg) - (TEMP_W+1)'(margin_below_reg);
    assign thr_off = (TEMP_W+1)'(setpoint_reg) - (TEMP_W+1)'(margin_above_reg);
    assign d1      = (TEMP_W+1)'(hist1_reg) - (TEMP_W+1)'(ct_reg);
    assign d2      = (TEMP_W+1)'(hist2_reg) - (TEMP_W+1)'(ct_reg);
    assign fall13  = (TEMP_W+1)'({1'b0, fall_limit_reg});
    assign elapsed    = item.now_ms - last_event_reg;
    assign event_fire = elapsed > event_interval_reg;

    always_comb
    begin
        relay_next       = relay_reg;
        time_on_next     = time_on_reg;
        time_off_next    = time_off_reg;
        last_event_next  = last_event_reg;
        offset_on_next   = offset_on_reg;
        offset_off_next  = offset_off_reg;
        offset_base_next = offset_base_reg;
        ct_next          = ct_reg;
        hist1_next       = hist1_reg;
        hist2_next       = hist2_reg;
        relay_mid        = relay_reg;
        on_mid           = offset_on_reg;
        if (commit)
        begin
            if (item.op == OP_SAMPLE)
            begin
                if (relay_reg)
                begin
                    offset_on_next = ofs_on_new;
                    ct_next        = sat_temp(temp_on);
                end
                else if (offset_off_reg > 16'sd0)
                begin
                    offset_off_next = ofs_off_new;
                    ct_next         = sat_temp(temp_off);
                end
                else
                begin
                    ct_next = item.raw_temp;
                end
            end
            else
            begin
                if (event_fire)
                begin
                    last_event_next = item.now_ms;
                    if ((ct_reg <= thr_on) && ((d1 <= fall13) || (d2 <= fall13)) && !relay_reg)
                    begin
                        relay_mid    = 1'b1;
                        time_on_next = item.now_ms;
                        on_mid       = offset_off_reg;
                    end
                    if ((ct_reg >= thr_off) && relay_mid)
                    begin
                        relay_mid        = 1'b0;
                        time_off_next    = item.now_ms;
                        offset_off_next  = on_mid;
                        offset_base_next = on_mid;
                    end
                    relay_next     = relay_mid;
                    offset_on_next = on_mid;
                end
                hist2_next = hist1_reg;
                hist1_next = ct_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg       <= 1'b0;
            time_on_reg     <= '0;
            time_off_reg    <= '0;
            last_event_reg  <= '0;
            offset_on_reg   <= '0;
            offset_off_reg  <= '0;
            offset_base_reg <= '0;
            ct_reg          <= '0;
            hist1_reg       <= '0;
            hist2_reg       <= '0;
        end
        else
        begin
            relay_reg       <= relay_next;
            time_on_reg     <= time_on_next;
            time_off_reg    <= time_off_next;
            last_event_reg  <= last_event_next;
            offset_on_reg   <= offset_on_next;
            offset_off_reg  <= offset_off_next;
            offset_base_reg <= offset_base_next;
            ct_reg          <= ct_next;
            hist1_reg       <= hist1_next;
            hist2_reg       <= hist2_next;
        end
    end

    assign timing.time_on  = time_on_reg;
    assign timing.time_off = time_off_reg;
    assign timing.rate_on  = heat_rate_on_reg;
    assign timing.rate_off = heat_rate_off_reg;
    assign relay_on        = relay_next;
    assign temp_corrected  = ct_next;

    a_relay_by_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(relay_reg) |-> $past(commit && (item.op == OP_TICK)))
        else $error("relay changed without a committed tick");

    a_temp_by_sample: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(ct_reg) |-> $past(commit && (item.op == OP_SAMPLE)))
        else $error("corrected temperature changed without a committed sample");

    a_event_time: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(last_event_reg) |-> $past(commit && (item.op == OP_TICK) && event_fire))
        else $error("event time moved without a control event");

endmodule

// File: rtl/thermostat_relay_with_heat_comp_core.sv
// An item passes the input, seconds, product, scale and output registers in turn.
// Throughput: one item per cycle while the output is not stalled; a sample
// that follows a tick waits in the input stage until that tick has updated the state.
// The heat path is three stages: seconds by reciprocal, rate product, scale by reciprocal.
// Reset is asynchronous, active low, and restores valid flags, config and state.
module thermostat_relay_with_heat_comp_core
    import thrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // now_ms[31:0], raw_temp[43:32], zero
    input  logic                  s_axis_tuser,   // op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // relay_on[0], temp_corrected[12:1], zero
);

    thrc_item_t           s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic [SECS_W-1:0]    secs_on_reg, secs_off_reg;
    logic [PROD_W-1:0]    prod_on_reg, prod_off_reg;
    logic [HEAT_W-1:0]    heat_on_reg, heat_off_reg;
    logic                 out_relay_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;

    thrc_timing_t         timing;
    logic                 relay_on;
    logic signed [TEMP_W-1:0] temp_corrected;

    logic [TIME_W-1:0]    delta_on, delta_off;
    logic [TIME_W+MS_RECIP_W-1:0] ms_prod_on, ms_prod_off;
    logic                 rdy_out, rdy2, rdy3, rdy4, rdy1;
    logic                 adv1, adv2, adv3, adv4;
    logic                 hazard;

    function automatic logic [HEAT_W-1:0] scale_heat(input logic [PROD_W-1:0] prod);
        logic [SCALE_IN_W-1:0]               x;
        logic [SCALE_IN_W+SCALE_RECIP_W-1:0] m;
        logic [HEAT_W-1:0]                   h;
        x = prod[SCALE_PRESHIFT +: SCALE_IN_W];
        m = (SCALE_IN_W+SCALE_RECIP_W)'(x) * (SCALE_IN_W+SCALE_RECIP_W)'(SCALE_RECIP);
        if (prod >= HEAT_SAT_LIMIT)
            h = HEAT_MAX;
        else
            h = {1'b0, m[SCALE_SHIFT +: OFS_W]};
        return h;
    endfunction

    assign rdy_out = !out_valid_reg || m_axis_tready;
    assign rdy4    = !v4_reg || rdy_out;
    assign adv4    = v4_reg && rdy_out;
    assign rdy3    = !v3_reg || rdy4;
    assign adv3    = v3_reg && rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign adv2    = v2_reg && rdy3;

    // A sample reads the switch times here, so it waits for ticks ahead of it.
    assign hazard = (s1_item_reg.op == OP_SAMPLE) &&
                    ((v2_reg && (s2_item_reg.op == OP_TICK)) ||
                     (v3_reg && (s3_item_reg.op == OP_TICK)) ||
                     (v4_reg && (s4_item_reg.op == OP_TICK)));
    assign adv1   = v1_reg && rdy2 && !hazard;
    assign rdy1   = !v1_reg || adv1;
    assign s_axis_tready = rdy1;

    assign delta_on    = s1_item_reg.now_ms - timing.time_on;
    assign delta_off   = s1_item_reg.now_ms - timing.time_off;
    assign ms_prod_on  = (TIME_W+MS_RECIP_W)'(delta_on) * (TIME_W+MS_RECIP_W)'(MS_RECIP);
    assign ms_prod_off = (TIME_W+MS_RECIP_W)'(delta_off) * (TIME_W+MS_RECIP_W)'(MS_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_axis_tvalid;
            if (rdy2)
                v2_reg <= adv1;
            if (rdy3)
                v3_reg <= adv2;
            if (rdy4)
                v4_reg <= adv3;
            if (rdy_out)
                out_valid_reg <= adv4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && rdy1)
        begin
            s1_item_reg.op       <= thrc_op_t'(s_axis_tuser);
            s1_item_reg.now_ms   <= s_axis_tdata[TIME_W-1:0];
            s1_item_reg.raw_temp <= s_axis_tdata[TIME_W +: TEMP_W];
        end
        if (adv1)
        begin
            s2_item_reg  <= s1_item_reg;
            secs_on_reg  <= ms_prod_on[MS_SHIFT +: SECS_W];
            secs_off_reg <= ms_prod_off[MS_SHIFT +: SECS_W];
        end
        if (adv2)
        begin
            s3_item_reg  <= s2_item_reg;
            prod_on_reg  <= PROD_W'(secs_on_reg) * PROD_W'(timing.rate_on);
            prod_off_reg <= PROD_W'(secs_off_reg) * PROD_W'(timing.rate_off);
        end
        if (adv3)
        begin
            s4_item_reg  <= s3_item_reg;
            heat_on_reg  <= scale_heat(prod_on_reg);
            heat_off_reg <= scale_heat(prod_off_reg);
        end
        if (adv4)
        begin
            out_relay_reg <= relay_on;
            out_temp_reg  <= temp_corrected;
        end
    end

    thrc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .commit         (adv4),
        .item           (s4_item_reg),
        .heat_on        (heat_on_reg),
        .heat_off       (heat_off_reg),
        .timing         (timing),
        .relay_on       (relay_on),
        .temp_corrected (temp_corrected)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-TEMP_W-1){1'b0}}, out_temp_reg, out_relay_reg};

    a_sample_behind_tick2: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && (s2_item_reg.op == OP_SAMPLE)) |->
            !((v3_reg && (s3_item_reg.op == OP_TICK)) || (v4_reg && (s4_item_reg.op == OP_TICK))))
        else $error("sample passed the input stage with a tick still ahead");

    a_sample_behind_tick3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (s3_item_reg.op == OP_SAMPLE)) |-> !(v4_reg && (s4_item_reg.op == OP_TICK)))
        else $error("sample in the product stage with a tick still ahead");

    a_heat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> ((heat_on_reg <= HEAT_MAX) && (heat_off_reg <= HEAT_MAX)))
        else $error("heat amount above its clamp");

endmodule
